// ----- rtl/goertzel_peak_tracker_macros.svh -----
// Assertion macros used by the checker file of the peak tracker.
// Each macro expands to one labeled concurrent assertion with an async reset guard.
`ifndef GOERTZEL_PEAK_TRACKER_MACROS_SVH
`define GOERTZEL_PEAK_TRACKER_MACROS_SVH

// Same-cycle implication.
`define GPT_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define GPT_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/gpt_pkg.sv -----
// Shared constants, types and command codes of the Goertzel peak tracker.
// Used by the controller, the datapath, the multiplier and the checker.
`timescale 1ns / 1ps
`default_nettype none

package gpt_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int ACC_BITS    = 48;
	localparam int TOP_COUNT   = 3;
	localparam int FRAC_BITS   = 14;
	localparam int COEFF_BITS  = 16;
	localparam int FREQ_BITS   = 11;
	localparam int MAG_OUT_W   = 63;
	localparam int SHOWN_PEAKS = 3;

	localparam int CHUNK_W   = 16;
	localparam int D_CHUNKS  = (ACC_BITS + CHUNK_W - 1) / CHUNK_W;
	localparam int U_BITS    = ACC_BITS + COEFF_BITS;
	localparam int U_CHUNKS  = (U_BITS + CHUNK_W - 1) / CHUNK_W;
	localparam int B_PAD     = U_CHUNKS * CHUNK_W;
	localparam int IDX_W     = $clog2(U_CHUNKS);
	localparam int PP_W      = ACC_BITS + CHUNK_W + 1;
	localparam int PROD_W    = ACC_BITS + B_PAD;
	localparam int REC_W     = ACC_BITS + 4;
	localparam int MAG_SHIFT = 3 * FRAC_BITS;
	localparam int MAG_W_A   = PROD_W + FRAC_BITS + 2;
	localparam int MAG_W_B   = MAG_SHIFT + MAG_OUT_W + 2;
	localparam int MAG_W     = (MAG_W_A > MAG_W_B) ? MAG_W_A : MAG_W_B;

	typedef logic [SAMPLE_BITS-1:0]       sample_t;
	typedef logic signed [COEFF_BITS-1:0] coeff_t;
	typedef logic [FREQ_BITS-1:0]         freq_t;
	typedef logic signed [ACC_BITS-1:0]   acc_t;
	typedef logic [MAG_OUT_W-1:0]         mag_t;
	typedef logic [IDX_W-1:0]             idx_t;

	localparam idx_t IDX_D_TOP = idx_t'(D_CHUNKS - 1);
	localparam idx_t IDX_U_TOP = idx_t'(U_CHUNKS - 1);

	localparam logic [3:0] OP_NONE    = 4'd0;
	localparam logic [3:0] OP_MUL     = 4'd1;
	localparam logic [3:0] OP_REC     = 4'd2;
	localparam logic [3:0] OP_MAG_SET = 4'd3;
	localparam logic [3:0] OP_MAG_ADD = 4'd4;
	localparam logic [3:0] OP_MAG_SUB = 4'd5;
	localparam logic [3:0] OP_SAVE_U  = 4'd6;
	localparam logic [3:0] OP_FINAL   = 4'd7;
	localparam logic [3:0] OP_INSERT  = 4'd8;
	localparam logic [3:0] OP_OUT     = 4'd9;

	localparam logic A_D1 = 1'b0;
	localparam logic A_D2 = 1'b1;

	localparam logic [1:0] B_COEFF = 2'd0;
	localparam logic [1:0] B_D1    = 2'd1;
	localparam logic [1:0] B_D2    = 2'd2;
	localparam logic [1:0] B_U     = 2'd3;

	typedef struct packed {
		logic       load;
		logic [3:0] op;
		logic       a_sel;
		logic [1:0] b_sel;
		idx_t       idx;
		logic       lead;
	} cmd_t;

	typedef struct packed {
		logic last;
	} status_t;

endpackage

`default_nettype wire

// ----- rtl/goertzel_peak_tracker.sv -----
// Single-bin Goertzel filter with a sorted top-three peak table over a frequency sweep.
// Top level: joins gpt_ctrl and gpt_datapath; uses gpt_pkg.
//
// Each accepted sample goes through accept, one 48x16 multiply of the first delay
// register by the coefficient, and the saturating recurrence update. A sample with last
// set then runs on the shared 48x17-bit chunk multiplier: two 3-slice squares, one
// coefficient multiply and a 4-slice cross product, then the magnitude clamp, the table
// insert and the load of the result register. The result register frees the datapath,
// but a closing sample waits in its final cycle while an earlier result is still not
// taken.
`timescale 1ns / 1ps
`default_nettype none

module goertzel_peak_tracker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  gpt_pkg::sample_t sample,
	input  gpt_pkg::coeff_t  coeff,
	input  gpt_pkg::freq_t   freq_tag,
	input  logic             first,
	input  logic             last,
	input  logic             sweep_start,
	output logic             out_valid,
	input  logic             out_ready,
	output gpt_pkg::mag_t    magnitude,
	output gpt_pkg::freq_t   block_freq,
	output gpt_pkg::mag_t    peak0_mag,
	output gpt_pkg::freq_t   peak0_freq,
	output gpt_pkg::mag_t    peak1_mag,
	output gpt_pkg::freq_t   peak1_freq,
	output gpt_pkg::mag_t    peak2_mag,
	output gpt_pkg::freq_t   peak2_freq
);
	import gpt_pkg::*;

	cmd_t    cmd;
	status_t status;
	mag_t    pmag [SHOWN_PEAKS];
	freq_t   pfreq [SHOWN_PEAKS];

	gpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	gpt_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.sample      (sample),
		.coeff       (coeff),
		.freq_tag    (freq_tag),
		.first       (first),
		.last        (last),
		.sweep_start (sweep_start),
		.out_mag     (magnitude),
		.out_freq    (block_freq),
		.out_pmag    (pmag),
		.out_pfreq   (pfreq)
	);

	assign peak0_mag  = pmag[0];
	assign peak0_freq = pfreq[0];
	assign peak1_mag  = pmag[1];
	assign peak1_freq = pfreq[1];
	assign peak2_mag  = pmag[2];
	assign peak2_freq = pfreq[2];

endmodule

`default_nettype wire

// ----- rtl/gpt_mul.sv -----
// Chunked signed multiplier: one 16-bit slice of the second operand per cycle while en is high.
// Slices arrive most significant first and are accumulated Horner style. Uses gpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gpt_mul (
	input  logic                              clk,
	input  logic                              en,
	input  logic                              lead,
	input  gpt_pkg::acc_t                     a,
	input  logic signed [gpt_pkg::CHUNK_W:0]  chunk,
	output logic signed [gpt_pkg::PROD_W-1:0] prod
);
	import gpt_pkg::*;

	logic signed [PP_W-1:0]   pp;
	logic signed [PROD_W-1:0] pp_ext;
	logic signed [PROD_W-1:0] prod_q;

	assign pp     = PP_W'(a) * PP_W'(chunk);
	assign pp_ext = PROD_W'(pp);
	assign prod   = prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= lead ? pp_ext : (prod_q <<< CHUNK_W) + pp_ext;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/gpt_datapath.sv -----
// Datapath of the peak tracker: delay registers, recurrence, magnitude accumulation,
// peak table and output register. Driven by gpt_ctrl commands; uses gpt_pkg and gpt_mul.
`timescale 1ns / 1ps
`default_nettype none

module gpt_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  gpt_pkg::cmd_t      cmd,
	output gpt_pkg::status_t   status,
	input  gpt_pkg::sample_t   sample,
	input  gpt_pkg::coeff_t    coeff,
	input  gpt_pkg::freq_t     freq_tag,
	input  logic               first,
	input  logic               last,
	input  logic               sweep_start,
	output gpt_pkg::mag_t      out_mag,
	output gpt_pkg::freq_t     out_freq,
	output gpt_pkg::mag_t      out_pmag [gpt_pkg::SHOWN_PEAKS],
	output gpt_pkg::freq_t     out_pfreq [gpt_pkg::SHOWN_PEAKS]
);
	import gpt_pkg::*;

	sample_t                  sample_q;
	logic                     last_q;
	coeff_t                   coeff_q;
	freq_t                    freq_q;
	acc_t                     d1_q;
	acc_t                     d2_q;
	logic signed [U_BITS-1:0] u_q;
	logic signed [MAG_W-1:0]  macc_q;
	mag_t                     res_q;
	mag_t                     pmag_q [TOP_COUNT];
	freq_t                    pfreq_q [TOP_COUNT];
	mag_t                     omag_q;
	freq_t                    ofreq_q;

	acc_t                     mul_a;
	logic signed [B_PAD-1:0]  b_pad;
	logic [CHUNK_W-1:0]       chunk_bits;
	logic signed [CHUNK_W:0]  chunk;
	logic signed [PROD_W-1:0] prod;

	logic signed [REC_W-1:0]  rec_p;
	logic signed [REC_W-1:0]  rec_d2;
	logic signed [REC_W-1:0]  rec_s;
	logic signed [REC_W-1:0]  rec_sum;
	logic [REC_W-ACC_BITS:0]  rec_top;
	acc_t                     rec_q;

	logic signed [MAG_W-1:0]  prod_ext;
	logic                     mag_neg;
	logic                     mag_over;
	mag_t                     mag_next;

	logic [TOP_COUNT-1:0]     gt;
	mag_t                     new_mag [TOP_COUNT];
	freq_t                    new_freq [TOP_COUNT];

	assign status.last = last_q;

	assign mul_a = (cmd.a_sel == A_D2) ? d2_q : d1_q;

	always_comb begin
		case (cmd.b_sel)
			B_COEFF: b_pad = B_PAD'(coeff_q);
			B_D1:    b_pad = B_PAD'(d1_q);
			B_D2:    b_pad = B_PAD'(d2_q);
			B_U:     b_pad = B_PAD'(u_q);
			default: b_pad = B_PAD'(coeff_q);
		endcase
	end

	assign chunk_bits = b_pad[cmd.idx*CHUNK_W +: CHUNK_W];
	assign chunk      = $signed({cmd.lead & chunk_bits[CHUNK_W-1], chunk_bits});

	gpt_mul u_mul (
		.clk   (clk),
		.en    (cmd.op == OP_MUL),
		.lead  (cmd.lead),
		.a     (mul_a),
		.chunk (chunk),
		.prod  (prod)
	);

	assign rec_p   = REC_W'($signed(prod[ACC_BITS+CHUNK_W-1:FRAC_BITS]));
	assign rec_d2  = REC_W'(d2_q);
	assign rec_s   = REC_W'({sample_q, {FRAC_BITS{1'b0}}});
	assign rec_sum = rec_p - rec_d2 + rec_s;
	assign rec_top = rec_sum[REC_W-1:ACC_BITS-1];

	always_comb begin
		if ((&rec_top) || !(|rec_top)) begin
			rec_q = rec_sum[ACC_BITS-1:0];
		end else if (rec_sum[REC_W-1]) begin
			rec_q = {1'b1, {(ACC_BITS-1){1'b0}}};
		end else begin
			rec_q = {1'b0, {(ACC_BITS-1){1'b1}}};
		end
	end

	assign prod_ext = MAG_W'(prod);
	assign mag_neg  = macc_q[MAG_W-1];
	assign mag_over = |macc_q[MAG_W-2:MAG_SHIFT+MAG_OUT_W];

	always_comb begin
		if (mag_neg) begin
			mag_next = '0;
		end else if (mag_over) begin
			mag_next = '1;
		end else begin
			mag_next = macc_q[MAG_SHIFT+MAG_OUT_W-1:MAG_SHIFT];
		end
	end

	// The table stays sorted, so the compare results are monotone down the table.
	always_comb begin
		for (int k = 0; k < TOP_COUNT; k++) begin
			gt[k] = res_q > pmag_q[k];
		end
		new_mag[0]  = gt[0] ? res_q : pmag_q[0];
		new_freq[0] = gt[0] ? freq_q : pfreq_q[0];
		for (int k = 1; k < TOP_COUNT; k++) begin
			if (gt[k-1]) begin
				new_mag[k]  = pmag_q[k-1];
				new_freq[k] = pfreq_q[k-1];
			end else if (gt[k]) begin
				new_mag[k]  = res_q;
				new_freq[k] = freq_q;
			end else begin
				new_mag[k]  = pmag_q[k];
				new_freq[k] = pfreq_q[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= 1'b0;
			coeff_q <= '0;
			freq_q  <= '0;
			d1_q    <= '0;
			d2_q    <= '0;
			for (int k = 0; k < TOP_COUNT; k++) begin
				pmag_q[k]  <= '0;
				pfreq_q[k] <= '0;
			end
		end else begin
			if (cmd.load) begin
				last_q <= last;
				if (first) begin
					coeff_q <= coeff;
					freq_q  <= freq_tag;
					d1_q    <= '0;
					d2_q    <= '0;
					if (sweep_start) begin
						for (int k = 0; k < TOP_COUNT; k++) begin
							pmag_q[k]  <= '0;
							pfreq_q[k] <= '0;
						end
					end
				end
			end
			if (cmd.op == OP_REC) begin
				d2_q <= d1_q;
				d1_q <= rec_q;
			end
			if (cmd.op == OP_INSERT) begin
				for (int k = 0; k < TOP_COUNT; k++) begin
					pmag_q[k]  <= new_mag[k];
					pfreq_q[k] <= new_freq[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= sample;
		end
		case (cmd.op)
			OP_SAVE_U:  u_q    <= prod[U_BITS-1:0];
			OP_MAG_SET: macc_q <= prod_ext <<< FRAC_BITS;
			OP_MAG_ADD: macc_q <= macc_q + (prod_ext <<< FRAC_BITS);
			OP_MAG_SUB: macc_q <= macc_q - prod_ext;
			OP_FINAL:   res_q  <= mag_next;
			OP_OUT: begin
				omag_q  <= res_q;
				ofreq_q <= freq_q;
			end
			default: begin
			end
		endcase
	end

	assign out_mag  = omag_q;
	assign out_freq = ofreq_q;

	for (genvar k = 0; k < SHOWN_PEAKS; k++) begin : g_show
		if (k < TOP_COUNT) begin : g_live
			mag_t  spmag_q;
			freq_t spfreq_q;

			always_ff @(posedge clk) begin
				if (cmd.op == OP_OUT) begin
					spmag_q  <= pmag_q[k];
					spfreq_q <= pfreq_q[k];
				end
			end

			assign out_pmag[k]  = spmag_q;
			assign out_pfreq[k] = spfreq_q;
		end else begin : g_none
			assign out_pmag[k]  = '0;
			assign out_pfreq[k] = '0;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/gpt_ctrl.sv -----
// Controller of the peak tracker: sequences the recurrence and, on a closing sample,
// the magnitude, table insert and result handshake. Uses gpt_pkg; drives gpt_datapath.
`timescale 1ns / 1ps
`default_nettype none

module gpt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  gpt_pkg::status_t status,
	output gpt_pkg::cmd_t    cmd
);
	import gpt_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_RMUL   = 4'd1;
	localparam logic [3:0] S_RUPD   = 4'd2;
	localparam logic [3:0] S_SQ1    = 4'd3;
	localparam logic [3:0] S_SQ1A   = 4'd4;
	localparam logic [3:0] S_SQ2    = 4'd5;
	localparam logic [3:0] S_SQ2A   = 4'd6;
	localparam logic [3:0] S_UMUL   = 4'd7;
	localparam logic [3:0] S_USAVE  = 4'd8;
	localparam logic [3:0] S_XMUL   = 4'd9;
	localparam logic [3:0] S_XSUB   = 4'd10;
	localparam logic [3:0] S_FINAL  = 4'd11;
	localparam logic [3:0] S_INSERT = 4'd12;
	localparam logic [3:0] S_OUT    = 4'd13;

	logic [3:0] state_q;
	logic [3:0] state_d;
	idx_t       idx_q;
	idx_t       idx_d;
	logic       out_valid_q;
	logic       out_load;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load  = 1'b0;
		cmd.op    = OP_NONE;
		cmd.a_sel = A_D1;
		cmd.b_sel = B_COEFF;
		cmd.idx   = idx_q;
		cmd.lead  = 1'b0;
		state_d   = state_q;
		idx_d     = idx_q;
		out_load  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_RMUL;
				end
			end
			S_RMUL: begin
				cmd.op   = OP_MUL;
				cmd.idx  = '0;
				cmd.lead = 1'b1;
				state_d  = S_RUPD;
			end
			S_RUPD: begin
				cmd.op = OP_REC;
				if (status.last) begin
					idx_d   = IDX_D_TOP;
					state_d = S_SQ1;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_SQ1: begin
				cmd.op    = OP_MUL;
				cmd.b_sel = B_D1;
				cmd.lead  = (idx_q == IDX_D_TOP);
				if (idx_q == '0) begin
					state_d = S_SQ1A;
				end else begin
					idx_d = idx_q - 1'b1;
				end
			end
			S_SQ1A: begin
				cmd.op  = OP_MAG_SET;
				idx_d   = IDX_D_TOP;
				state_d = S_SQ2;
			end
			S_SQ2: begin
				cmd.op    = OP_MUL;
				cmd.a_sel = A_D2;
				cmd.b_sel = B_D2;
				cmd.lead  = (idx_q == IDX_D_TOP);
				if (idx_q == '0) begin
					state_d = S_SQ2A;
				end else begin
					idx_d = idx_q - 1'b1;
				end
			end
			S_SQ2A: begin
				cmd.op  = OP_MAG_ADD;
				state_d = S_UMUL;
			end
			S_UMUL: begin
				cmd.op   = OP_MUL;
				cmd.idx  = '0;
				cmd.lead = 1'b1;
				state_d  = S_USAVE;
			end
			S_USAVE: begin
				cmd.op  = OP_SAVE_U;
				idx_d   = IDX_U_TOP;
				state_d = S_XMUL;
			end
			S_XMUL: begin
				cmd.op    = OP_MUL;
				cmd.a_sel = A_D2;
				cmd.b_sel = B_U;
				cmd.lead  = (idx_q == IDX_U_TOP);
				if (idx_q == '0) begin
					state_d = S_XSUB;
				end else begin
					idx_d = idx_q - 1'b1;
				end
			end
			S_XSUB: begin
				cmd.op  = OP_MAG_SUB;
				state_d = S_FINAL;
			end
			S_FINAL: begin
				cmd.op  = OP_FINAL;
				state_d = S_INSERT;
			end
			S_INSERT: begin
				cmd.op  = OP_INSERT;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.op   = OP_OUT;
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/gpt_checker.sv -----
// Port-level checker for goertzel_peak_tracker, bound to the top level below.
// Depends on gpt_pkg and goertzel_peak_tracker_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "goertzel_peak_tracker_macros.svh"

module gpt_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input gpt_pkg::sample_t sample,
	input gpt_pkg::coeff_t  coeff,
	input gpt_pkg::freq_t   freq_tag,
	input logic             first,
	input logic             last,
	input logic             sweep_start,
	input logic             out_valid,
	input logic             out_ready,
	input gpt_pkg::mag_t    magnitude,
	input gpt_pkg::freq_t   block_freq,
	input gpt_pkg::mag_t    peak0_mag,
	input gpt_pkg::freq_t   peak0_freq,
	input gpt_pkg::mag_t    peak1_mag,
	input gpt_pkg::freq_t   peak1_freq,
	input gpt_pkg::mag_t    peak2_mag,
	input gpt_pkg::freq_t   peak2_freq
);
	import gpt_pkg::*;

	localparam int IN_W  = SAMPLE_BITS + COEFF_BITS + FREQ_BITS + 3;
	localparam int OUT_W = 4 * (MAG_OUT_W + FREQ_BITS);

	logic [IN_W-1:0]  in_bus;
	logic [OUT_W-1:0] out_bus;
	logic             in_wait;
	logic             out_wait;
	logic             peaks_sorted;

	assign in_bus   = {sample, coeff, freq_tag, first, last, sweep_start};
	assign out_bus  = {magnitude, block_freq, peak0_mag, peak0_freq,
		peak1_mag, peak1_freq, peak2_mag, peak2_freq};
	assign in_wait  = in_valid && !in_ready;
	assign out_wait = out_valid && !out_ready;
	assign peaks_sorted = (peak0_mag >= peak1_mag) && (peak1_mag >= peak2_mag);

	// A waiting request keeps its payload.
	`GPT_ASSERT_NEXT(a_in_hold, clk, arst_n, in_wait, in_valid && $stable(in_bus), "input moved")

	// A stalled result keeps its payload.
	`GPT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_wait, out_valid && $stable(out_bus), "result moved")

	// While a result is valid, the shown peak table is sorted, largest first.
	`GPT_ASSERT_IMP(a_peak_order, clk, arst_n, out_valid, peaks_sorted, "peaks out of order")

	// No block magnitude exceeds the largest peak after its insert.
	`GPT_ASSERT_IMP(a_mag_bound, clk, arst_n, out_valid, magnitude <= peak0_mag, "above peak0")

	// Samples are processed one at a time.
	`GPT_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready, "taken while busy")

endmodule

bind goertzel_peak_tracker gpt_checker u_chk (.*);

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for goertzel_peak_tracker: drives sample requests, predicts
// each bin magnitude and the peak table, and compares every result field by field.
// Depends on gpt_pkg and the RTL of goertzel_peak_tracker.
`timescale 1ns / 1ps

module testbench;
	import gpt_pkg::*;

	typedef logic signed [191:0] wide_t;

	localparam wide_t ACC_TOP    = (wide_t'(1) <<< (ACC_BITS - 1)) - 1;
	localparam wide_t ACC_BOTTOM = -ACC_TOP - 1;
	localparam wide_t MAG_TOP    = (wide_t'(1) <<< 63) - 1;
	localparam int    LONG_HOLD  = 600;
	localparam int    SETTLE_CYCLES = 60;

	typedef struct {
		mag_t  mag;
		freq_t freq;
		mag_t  peak_mag[SHOWN_PEAKS];
		freq_t peak_freq[SHOWN_PEAKS];
	} bin_result_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    in_valid = 1'b0;
	logic    in_ready;
	sample_t sample = '0;
	coeff_t  coeff = '0;
	freq_t   freq_tag = '0;
	logic    first = 1'b0;
	logic    last = 1'b0;
	logic    sweep_start = 1'b0;
	logic    out_valid;
	logic    out_ready = 1'b0;
	mag_t    magnitude;
	freq_t   block_freq;
	mag_t    peak0_mag;
	freq_t   peak0_freq;
	mag_t    peak1_mag;
	freq_t   peak1_freq;
	mag_t    peak2_mag;
	freq_t   peak2_freq;

	acc_t        bin_d1 = '0;
	acc_t        bin_d2 = '0;
	coeff_t      bin_coeff = '0;
	freq_t       bin_freq = '0;
	logic [63:0] table_mag[TOP_COUNT] = '{default: '0};
	freq_t       table_freq[TOP_COUNT] = '{default: '0};
	bin_result_t expected_bins[$];

	int   err_count = 0;
	bit   idle_on = 1'b0;
	bit   hold_req = 1'b0;
	int   stall_left = 0;

	goertzel_peak_tracker u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample),
		.coeff      (coeff),
		.freq_tag   (freq_tag),
		.first      (first),
		.last       (last),
		.sweep_start(sweep_start),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.magnitude  (magnitude),
		.block_freq (block_freq),
		.peak0_mag  (peak0_mag),
		.peak0_freq (peak0_freq),
		.peak1_mag  (peak1_mag),
		.peak1_freq (peak1_freq),
		.peak2_mag  (peak2_mag),
		.peak2_freq (peak2_freq)
	);

	always #1 clk = ~clk;

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic report_error(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		err_count++;
	endtask

	task automatic check_field(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_error($sformatf("%s is %0h, expected %0h", what, got, want));
	endtask

	function automatic void predict_bin(input sample_t s, input coeff_t c, input freq_t f,
			input logic fi, input logic la, input logic sw);
		wide_t       acc;
		wide_t       energy;
		logic [63:0] mag64;
		bin_result_t r;
		int          pos;
		int          k;
		if (fi) begin
			bin_coeff = c;
			bin_freq  = f;
			bin_d1    = '0;
			bin_d2    = '0;
			if (sw) begin
				for (k = 0; k < TOP_COUNT; k++) begin
					table_mag[k]  = '0;
					table_freq[k] = '0;
				end
			end
		end
		acc = ((wide_t'(bin_coeff) * wide_t'(bin_d1)) >>> FRAC_BITS) - wide_t'(bin_d2)
			+ (wide_t'(s) <<< FRAC_BITS);
		if (acc > ACC_TOP)
			acc = ACC_TOP;
		if (acc < ACC_BOTTOM)
			acc = ACC_BOTTOM;
		bin_d2 = bin_d1;
		bin_d1 = acc[ACC_BITS-1:0];
		if (!la)
			return;

		energy = ((wide_t'(bin_d1) * wide_t'(bin_d1) + wide_t'(bin_d2) * wide_t'(bin_d2))
			<<< FRAC_BITS) - wide_t'(bin_d1) * wide_t'(bin_d2) * wide_t'(bin_coeff);
		energy = energy >>> (3 * FRAC_BITS);
		if (energy < 0)
			mag64 = '0;
		else if (energy > MAG_TOP)
			mag64 = MAG_TOP[63:0];
		else
			mag64 = energy[63:0];

		// Strictly greater wins a slot; the entries below it move down by one.
		pos = TOP_COUNT;
		for (k = TOP_COUNT - 1; k >= 0; k--) begin
			if (mag64 > table_mag[k])
				pos = k;
		end
		if (pos < TOP_COUNT) begin
			for (k = TOP_COUNT - 1; k > pos; k--) begin
				table_mag[k]  = table_mag[k-1];
				table_freq[k] = table_freq[k-1];
			end
			table_mag[pos]  = mag64;
			table_freq[pos] = bin_freq;
		end

		r.mag  = mag64[MAG_OUT_W-1:0];
		r.freq = bin_freq;
		for (k = 0; k < SHOWN_PEAKS; k++) begin
			r.peak_mag[k]  = (k < TOP_COUNT) ? table_mag[k][MAG_OUT_W-1:0] : '0;
			r.peak_freq[k] = (k < TOP_COUNT) ? table_freq[k] : '0;
		end
		expected_bins.push_back(r);
	endfunction

	function automatic sample_t pick_sample();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic coeff_t pick_coeff();
		case ($urandom_range(0, 9))
			0: return coeff_t'(-32768);
			1: return coeff_t'(32767);
			2: return '0;
			default: return coeff_t'($urandom);
		endcase
	endfunction

	function automatic freq_t pick_freq();
		if ($urandom_range(0, 7) == 0)
			return freq_t'($urandom);
		return freq_t'($urandom_range(0, 1500));
	endfunction

	// Called at a rising edge; returns at the edge where the request is accepted.
	task automatic send_item(input sample_t s, input coeff_t c, input freq_t f,
			input logic fi, input logic la, input logic sw);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 18);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		sample      <= s;
		coeff       <= c;
		freq_tag    <= f;
		first       <= fi;
		last        <= la;
		sweep_start <= sw;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_bin(s, c, f, fi, la, sw);
	endtask

	// A fill value below zero gives random samples.
	task automatic send_block(input coeff_t c, input freq_t f, input logic sw, input int len,
			input logic opened, input logic closed, input int fill);
		sample_t s;
		int      k;
		for (k = 0; k < len; k++) begin
			s = (fill < 0) ? pick_sample() : sample_t'(fill);
			if (k == 0 && opened)
				send_item(s, c, f, 1'b1, closed && len == 1, sw);
			else
				send_item(s, pick_coeff(), pick_freq(), 1'b0, closed && k == len - 1,
					$urandom_range(0, 7) == 0);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_bins.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Samples before any opening request run with the reset coefficient and tag.
	task automatic test_unopened_block();
		send_item('0, '0, '0, 1'b0, 1'b1, 1'b0);
		send_item('1, coeff_t'(12345), freq_t'(999), 1'b0, 1'b1, 1'b1);
	endtask

	task automatic test_single_sample();
		send_item('1, coeff_t'(-32768), freq_t'(1500), 1'b1, 1'b1, 1'b1);
		send_item('0, coeff_t'(32767), '0, 1'b1, 1'b1, 1'b1);
		send_item('1, coeff_t'(32767), freq_t'(2047), 1'b1, 1'b1, 1'b0);
	endtask

	// Equal magnitudes must not displace an entry; larger ones push the rest down.
	task automatic test_peak_ordering();
		send_block('0, freq_t'(100), 1'b1, 2, 1'b1, 1'b1, 1000);
		send_block('0, freq_t'(200), 1'b0, 2, 1'b1, 1'b1, 1000);
		send_block('0, freq_t'(300), 1'b0, 2, 1'b1, 1'b1, 1000);
		send_block('0, freq_t'(400), 1'b0, 2, 1'b1, 1'b1, 4095);
		send_block('0, freq_t'(500), 1'b0, 2, 1'b1, 1'b1, 1);
		send_block('0, freq_t'(600), 1'b0, 2, 1'b1, 1'b1, 2000);
	endtask

	task automatic test_backpressure();
		int k;
		hold_req = 1'b1;
		for (k = 0; k < 40; k++)
			send_block(pick_coeff(), pick_freq(), $urandom_range(0, 3) == 0,
				$urandom_range(1, 3), 1'b1, 1'b1, -1);
		wait_drained();
	endtask

	// A coefficient of -2 driven at the Nyquist rate grows quadratically, which drives
	// the delay registers and the products to very wide values.
	task automatic test_resonance();
		int k;
		send_item('1, coeff_t'(-32768), freq_t'(750), 1'b1, 1'b0, 1'b1);
		for (k = 1; k < 640; k++)
			send_item((k % 2 == 0) ? sample_t'(4095) : sample_t'(0), pick_coeff(),
				pick_freq(), 1'b0, k % 128 == 127, 1'b0);
		send_block(pick_coeff(), pick_freq(), 1'b0, 6, 1'b1, 1'b1, -1);
	endtask

	task automatic test_random(input int n_items);
		int sent;
		int seg_end;
		int len;
		int kind;
		sent = 0;
		seg_end = 0;
		while (sent < n_items) begin
			if (sent >= n_items - 200) begin
				idle_on = 1'b0;
			end else if (sent >= seg_end) begin
				idle_on = $urandom_range(0, 3) != 0;
				seg_end = sent + $urandom_range(60, 200);
			end
			kind = $urandom_range(0, 19);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 48) : $urandom_range(1, 10);
			if (kind == 0) begin
				send_item(sample_t'($urandom), coeff_t'($urandom), freq_t'($urandom),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
				sent++;
			end else if (kind == 1) begin
				send_block(pick_coeff(), pick_freq(), 1'b0, len, 1'b0, 1'b1, -1);
				sent += len;
			end else if (kind == 2) begin
				send_block(pick_coeff(), pick_freq(), $urandom_range(0, 5) == 0, len,
					1'b1, 1'b0, -1);
				sent += len;
			end else begin
				send_block(pick_coeff(), pick_freq(), $urandom_range(0, 5) == 0, len,
					1'b1, 1'b1, -1);
				sent += len;
			end
		end
	endtask

	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			stall_left = LONG_HOLD;
		end else if (stall_left == 0 && idle_on && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(1, 18);
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		bin_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_bins.size() == 0) begin
				report_error("result with no request pending");
			end else begin
				want = expected_bins.pop_front();
				check_field("magnitude", 64'(magnitude), 64'(want.mag));
				check_field("block_freq", 64'(block_freq), 64'(want.freq));
				check_field("peak0_mag", 64'(peak0_mag), 64'(want.peak_mag[0]));
				check_field("peak0_freq", 64'(peak0_freq), 64'(want.peak_freq[0]));
				check_field("peak1_mag", 64'(peak1_mag), 64'(want.peak_mag[1]));
				check_field("peak1_freq", 64'(peak1_freq), 64'(want.peak_freq[1]));
				check_field("peak2_mag", 64'(peak2_mag), 64'(want.peak_mag[2]));
				check_field("peak2_freq", 64'(peak2_freq), 64'(want.peak_freq[2]));
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_on = 1'b0;
		test_unopened_block();
		test_single_sample();
		test_peak_ordering();
		idle_on = 1'b1;
		test_backpressure();
		test_resonance();
		test_random(600);
		wait_drained();
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
